// File: rtl/cotm_pkg.sv
package cotm_pkg;

  localparam int TS_W       = 48;
  localparam int OFS_W      = 49;
  localparam int DLY_W      = 47;
  localparam int WINDOW_DEF = 8;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic calc;
    logic offs;
    logic scan_clr;
    logic scan_rd;
    logic sum_ext;
    logic trim;
    logic div_start;
    logic out_load;
    logic out_mean;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic will_full;
    logic ring_full;
    logic scan_last;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/cotm_ctrl.sv
module cotm_ctrl
  import cotm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CALC  = 4'd1;
  localparam logic [3:0] ST_OFFS  = 4'd2;
  localparam logic [3:0] ST_SCAN  = 4'd3;
  localparam logic [3:0] ST_SCANE = 4'd4;
  localparam logic [3:0] ST_SUMX  = 4'd5;
  localparam logic [3:0] ST_TRIM  = 4'd6;
  localparam logic [3:0] ST_DIVGO = 4'd7;
  localparam logic [3:0] ST_DIVW  = 4'd8;
  localparam logic [3:0] ST_DONEN = 4'd9;
  localparam logic [3:0] ST_DONEM = 4'd10;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_OFFS;
      end
      ST_OFFS: begin
        cmd_o.offs     = 1'b1;
        cmd_o.scan_clr = 1'b1;
        state_d        = sts_i.will_full ? ST_SCAN : ST_DONEN;
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_SCANE;
        end
      end
      // last read word lands in the accumulators here
      ST_SCANE: state_d = ST_SUMX;
      ST_SUMX: begin
        cmd_o.sum_ext = 1'b1;
        state_d       = ST_TRIM;
      end
      ST_TRIM: begin
        cmd_o.trim = 1'b1;
        state_d    = ST_DIVGO;
      end
      ST_DIVGO: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIVW;
      end
      ST_DIVW: begin
        if (sts_i.div_done) begin
          state_d = ST_DONEM;
        end
      end
      ST_DONEN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_DONEM: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_mean = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/cotm_div.sv
module cotm_div
  import cotm_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF,
  parameter int MAG_W  = OFS_W + $clog2(WINDOW)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [MAG_W-1:0] dividend_i,
  output logic [MAG_W-1:0] quot_o,
  output logic             done_o
);

  localparam int             DW      = $clog2(WINDOW - 1);
  localparam int             DIG_W   = 8;
  localparam int             STEPS   = (MAG_W + DIG_W - 1) / DIG_W;
  localparam int             PAD_W   = STEPS * DIG_W;
  localparam int             CNT_W   = $clog2(STEPS + 1);
  localparam int             X_W     = DW + DIG_W;
  localparam int             M_W     = X_W + 1;
  localparam int             SHIFT   = X_W + $clog2(WINDOW - 2);
  localparam int             RECIP   = ((1 << SHIFT) + WINDOW - 3) / (WINDOW - 2);
  localparam logic [DW-1:0]  DIVISOR = DW'(WINDOW - 2);
  localparam logic [M_W-1:0] RECIP_C = M_W'(RECIP);

  logic [PAD_W-1:0]     q_q;
  logic [DW-1:0]        rem_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q, done_q;
  logic [X_W-1:0]       x;
  logic [X_W+M_W-1:0]   prod;
  logic [DIG_W-1:0]     dig;
  logic [X_W-1:0]       back;

  // long division by WINDOW - 2, one 8-bit digit a cycle
  // remainder stays below the divisor, so each partial dividend has a short
  // reciprocal that gives the exact digit
  assign x    = {rem_q, q_q[PAD_W-1 -: DIG_W]};
  assign prod = (X_W+M_W)'(x) * (X_W+M_W)'(RECIP_C);
  assign dig  = prod[SHIFT +: DIG_W];
  assign back = x - (X_W'(dig) * X_W'(DIVISOR));

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= PAD_W'(dividend_i);
      rem_q <= '0;
    end else if (busy_q) begin
      q_q   <= {q_q[PAD_W-DIG_W-1:0], dig};
      rem_q <= back[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quot_o = q_q[MAG_W-1:0];
  assign done_o = done_q;

endmodule

// File: rtl/cotm_dp.sv
module cotm_dp
  import cotm_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o,
  input  logic [TS_W-1:0]         client_send_time_i,
  input  logic [TS_W-1:0]         server_time_i,
  input  logic [TS_W-1:0]         local_receive_time_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OFS_W-1:0] offset_estimate_o,
  output logic [DLY_W-1:0]        one_way_delay_o,
  output logic                    window_full_o,
  output logic                    rtt_clamped_o
);

  localparam int IDX_W  = $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = OFS_W + $clog2(WINDOW);

  logic [TS_W-1:0]         sent_q, server_q, now_q;
  logic [OFS_W-1:0]        rtt;
  logic signed [OFS_W-1:0] diff_q, offset, offset_q;
  logic [DLY_W-1:0]        delay_q;
  logic                    clamped_q;

  logic signed [OFS_W-1:0] ring [WINDOW];
  logic [IDX_W-1:0]        slot_q, rd_addr_q;
  logic [FILL_W-1:0]       fill_q;
  logic signed [OFS_W-1:0] rd_data_q;
  logic                    rd_vld_q;

  logic signed [SUM_W-1:0] sum_q, trim_q;
  logic signed [OFS_W-1:0] min_q, max_q;
  logic signed [OFS_W:0]   ext_q;
  logic [SUM_W-1:0]        mag, quot;
  logic                    neg_q, div_done;
  logic [SUM_W-1:0]        mean_full;

  logic                    out_valid_q;
  logic signed [OFS_W-1:0] est_q;
  logic [DLY_W-1:0]        dly_out_q;
  logic                    full_out_q, clamp_out_q;

  assign rtt    = {1'b0, now_q} - {1'b0, sent_q};
  assign offset = diff_q + $signed({2'b00, delay_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      sent_q   <= client_send_time_i;
      server_q <= server_time_i;
      now_q    <= local_receive_time_i;
    end
    if (cmd_i.calc) begin
      clamped_q <= rtt[OFS_W-1];
      delay_q   <= rtt[OFS_W-1] ? '0 : rtt[DLY_W:1];
      diff_q    <= $signed({1'b0, server_q} - {1'b0, now_q});
    end
    if (cmd_i.offs) begin
      offset_q     <= offset;
      ring[slot_q] <= offset;
    end
    if (cmd_i.scan_rd) begin
      rd_data_q <= ring[rd_addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= '0;
      fill_q    <= '0;
      rd_addr_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_rd;
      if (cmd_i.offs) begin
        slot_q <= (slot_q == IDX_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
        if (fill_q != FILL_W'(WINDOW)) begin
          fill_q <= fill_q + 1'b1;
        end
      end
      if (cmd_i.scan_clr) begin
        rd_addr_q <= '0;
      end else if (cmd_i.scan_rd) begin
        rd_addr_q <= rd_addr_q + 1'b1;
      end
    end
  end

  // window sum and extremes, one word a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_clr) begin
      sum_q <= '0;
      min_q <= {1'b0, {(OFS_W-1){1'b1}}};
      max_q <= {1'b1, {(OFS_W-1){1'b0}}};
    end else if (rd_vld_q) begin
      sum_q <= sum_q + SUM_W'(rd_data_q);
      if (rd_data_q < min_q) min_q <= rd_data_q;
      if (rd_data_q > max_q) max_q <= rd_data_q;
    end
    if (cmd_i.sum_ext) begin
      ext_q <= (OFS_W+1)'(min_q) + (OFS_W+1)'(max_q);
    end
    if (cmd_i.trim) begin
      trim_q <= sum_q - SUM_W'(ext_q);
    end
    if (cmd_i.div_start) begin
      neg_q <= trim_q[SUM_W-1];
    end
  end

  assign mag = trim_q[SUM_W-1] ? SUM_W'(-trim_q) : SUM_W'(trim_q);

  cotm_div #(
    .WINDOW (WINDOW),
    .MAG_W  (SUM_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (mag),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  // quotient magnitude back to two's complement, truncated toward zero
  assign mean_full = neg_q ? (~quot + 1'b1) : quot;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      est_q       <= cmd_i.out_mean ? $signed(mean_full[OFS_W-1:0]) : offset_q;
      dly_out_q   <= delay_q;
      full_out_q  <= cmd_i.out_mean;
      clamp_out_q <= clamped_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.will_full = (fill_q >= FILL_W'(WINDOW - 1));
  assign sts_o.ring_full = (fill_q == FILL_W'(WINDOW));
  assign sts_o.scan_last = (rd_addr_q == IDX_W'(WINDOW - 1));
  assign sts_o.div_done  = div_done;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o       = out_valid_q;
  assign offset_estimate_o = est_q;
  assign one_way_delay_o   = dly_out_q;
  assign window_full_o     = full_out_q;
  assign rtt_clamped_o     = clamp_out_q;

endmodule

// File: rtl/clock_offset_trimmed_mean.sv
// while filling: each accepted word goes through calc and offset, then reports its own offset
// once full: ring scan, extremes sum, trim and divide, then the trimmed mean is reported
// the ring scan reads one word a cycle; the divider retires 8 quotient bits a cycle
// one reply in flight: the next word is taken once the result enters the output register,
// which waits while a stalled result holds the output register
// reset clears the controller, write slot, fill count and output valid; ring is not cleared
module clock_offset_trimmed_mean
  import cotm_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [TS_W-1:0]         client_send_time_i,
  input  logic [TS_W-1:0]         server_time_i,
  input  logic [TS_W-1:0]         local_receive_time_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OFS_W-1:0] offset_estimate_o,
  output logic [DLY_W-1:0]        one_way_delay_o,
  output logic                    window_full_o,
  output logic                    rtt_clamped_o
);

  cmd_t cmd;
  sts_t sts;

  cotm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cotm_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .client_send_time_i   (client_send_time_i),
    .server_time_i        (server_time_i),
    .local_receive_time_i (local_receive_time_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .offset_estimate_o    (offset_estimate_o),
    .one_way_delay_o      (one_way_delay_o),
    .window_full_o        (window_full_o),
    .rtt_clamped_o        (rtt_clamped_o)
  );

  // mean only once every ring entry holds a written offset
  a_mean_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.out_load && cmd.out_mean) |-> sts.ring_full)
    else $error("trimmed mean reported before ring full");

  a_newest_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.out_load && !cmd.out_mean) |-> !sts.ring_full)
    else $error("newest offset reported with ring full");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second word taken while one is in flight");

  a_div_not_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> !sts.div_done)
    else $error("divider done right after start");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import cotm_pkg::*;

  localparam int WIN            = WINDOW_DEF;
  localparam int RANDOM_REPLIES = 1330;
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int HOLD_AT        = 700;
  localparam int HOLD_CYCLES    = 400;
  localparam int PRINT_CAP      = 40;
  localparam logic [TS_W-1:0] TS_MAX = {TS_W{1'b1}};

  typedef struct packed {
    logic signed [OFS_W-1:0] offset;
    logic [DLY_W-1:0]        delay;
    logic                    full;
    logic                    clamped;
  } estimate_t;

  typedef struct {
    logic [TS_W-1:0] sent;
    logic [TS_W-1:0] server;
    logic [TS_W-1:0] now;
    bit              typed;
    estimate_t       want;
  } reply_row_t;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_valid   = 1'b0;
  logic                    in_stall;
  logic [TS_W-1:0]         send_ts    = '0;
  logic [TS_W-1:0]         server_ts  = '0;
  logic [TS_W-1:0]         recv_ts    = '0;
  logic                    out_valid;
  logic                    out_stall  = 1'b0;
  logic signed [OFS_W-1:0] offset_est;
  logic [DLY_W-1:0]        delay_est;
  logic                    full_flag;
  logic                    clamp_flag;

  // predictor copy of the offset window
  longint    ofs_ring [WIN];
  int        ring_slot;
  int        ring_fill;

  estimate_t  awaited_estimates [$];
  reply_row_t directed [$];
  int         mismatches = 0;
  int         words_in   = 0;
  int         cycles     = 0;
  int         burst_left = 0;
  bit         held       = 1'b0;
  logic [TS_W-1:0] drift = '0;

  clock_offset_trimmed_mean #(.WINDOW(WIN)) dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .client_send_time_i  (send_ts),
    .server_time_i       (server_ts),
    .local_receive_time_i(recv_ts),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .offset_estimate_o   (offset_est),
    .one_way_delay_o     (delay_est),
    .window_full_o       (full_flag),
    .rtt_clamped_o       (clamp_flag)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic estimate_t filter_reply(input logic [TS_W-1:0] sent,
                                             input logic [TS_W-1:0] server,
                                             input logic [TS_W-1:0] now);
    longint    rtt, dly, ofs, acc, lo, hi, est;
    estimate_t r;
    rtt = longint'({16'h0, now}) - longint'({16'h0, sent});
    r.clamped = (rtt < 0);
    if (rtt < 0) rtt = 0;
    dly = rtt / 2;
    ofs = longint'({16'h0, server}) + dly - longint'({16'h0, now});
    ofs_ring[ring_slot] = ofs;
    ring_slot = (ring_slot + 1) % WIN;
    if (ring_fill < WIN) ring_fill++;
    r.full = (ring_fill == WIN);
    est = ofs;
    if (r.full) begin
      acc = 0;
      lo  = ofs_ring[0];
      hi  = ofs_ring[0];
      for (int i = 0; i < WIN; i++) begin
        acc += ofs_ring[i];
        if (ofs_ring[i] < lo) lo = ofs_ring[i];
        if (ofs_ring[i] > hi) hi = ofs_ring[i];
      end
      // one min and one max dropped, division truncates toward zero
      est = (acc - lo - hi) / (WIN - 2);
    end
    r.offset = est[OFS_W-1:0];
    r.delay  = dly[DLY_W-1:0];
    return r;
  endfunction

  function automatic logic [TS_W-1:0] rand_ts();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TS_W-1:0];
  endfunction

  function automatic logic [TS_W-1:0] edge_ts();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return TS_MAX;
      2:       return TS_W'(1);
      default: return rand_ts();
    endcase
  endfunction

  function automatic reply_row_t mk_row(input logic [TS_W-1:0] sent,
                                        input logic [TS_W-1:0] server,
                                        input logic [TS_W-1:0] now,
                                        input bit typed, input estimate_t want);
    reply_row_t r;
    r.sent   = sent;
    r.server = server;
    r.now    = now;
    r.typed  = typed;
    r.want   = want;
    return r;
  endfunction

  function automatic reply_row_t random_reply();
    reply_row_t      r;
    logic [TS_W-1:0] rtt;
    int              kind;
    kind    = $urandom_range(0, 15);
    r.typed = 1'b0;
    r.want  = '0;
    r.now   = rand_ts();
    if ($urandom_range(0, 31) == 0)
      drift = ($urandom_range(0, 3) == 0) ? rand_ts()
                                          : TS_W'($urandom_range(0, 2000)) - TS_W'(1000);
    if (kind < 10) begin
      // plausible reply: round trip mostly short, offset near the current drift
      rtt = (kind == 0) ? (rand_ts() >> $urandom_range(1, 47))
                        : TS_W'($urandom_range(0, 250000));
      r.sent   = r.now - rtt;
      r.server = r.now - (rtt >> 1) + drift + TS_W'($urandom_range(0, 7));
    end else if (kind < 12) begin
      // client time ahead of receive time
      r.sent   = r.now + TS_W'($urandom_range(1, 5000));
      r.server = r.now + drift;
    end else if (kind < 14) begin
      r.sent   = rand_ts();
      r.server = rand_ts();
    end else begin
      r.sent   = edge_ts();
      r.server = edge_ts();
      r.now    = edge_ts();
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("[%0t] %s", $time, msg);
  endtask

  task automatic offer_reply(input reply_row_t row);
    estimate_t p;
    in_valid  <= 1'b1;
    send_ts   <= row.sent;
    server_ts <= row.server;
    recv_ts   <= row.now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = filter_reply(row.sent, row.server, row.now);
    awaited_estimates.push_back(row.typed ? row.want : p);
    words_in++;
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
  endtask

  initial begin
    ring_slot = 0;
    ring_fill = 0;
    foreach (ofs_ring[i]) ofs_ring[i] = 0;

    // ring filling: each word reports its own offset
    directed.push_back(mk_row('0, '0, '0, 1'b1, '{'0, '0, 1'b0, 1'b0}));
    directed.push_back(mk_row(TS_MAX, TS_MAX, TS_MAX, 1'b1, '{'0, '0, 1'b0, 1'b0}));
    directed.push_back(mk_row('0, '0, TS_MAX, 1'b1,
                              '{-49'sh8000_0000_0000, 47'h7FFF_FFFF_FFFF, 1'b0, 1'b0}));
    directed.push_back(mk_row(TS_MAX, '0, '0, 1'b1, '{'0, '0, 1'b0, 1'b1}));
    directed.push_back(mk_row('0, TS_MAX, '0, 1'b1,
                              '{49'sh0_FFFF_FFFF_FFFF, '0, 1'b0, 1'b0}));
    directed.push_back(mk_row(TS_W'(1), '0, '0, 1'b1, '{'0, '0, 1'b0, 1'b1}));
    directed.push_back(mk_row('0, '0, TS_W'(1), 1'b1, '{-49'sd1, '0, 1'b0, 1'b0}));
    // filling word, odd round trip, small negative sum truncated toward zero
    directed.push_back(mk_row('0, '0, TS_W'(3), 1'b0, '0));
    // repeated extremes in the window
    for (int i = 0; i < 4; i++) directed.push_back(mk_row('0, TS_MAX, '0, 1'b0, '0));
    for (int i = 0; i < 4; i++) directed.push_back(mk_row(TS_MAX, '0, TS_MAX, 1'b0, '0));
    for (int i = 0; i < 8; i++) directed.push_back(mk_row('0, TS_MAX, '0, 1'b0, '0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      pace_sender();
      offer_reply(directed[i]);
    end
    repeat (RANDOM_REPLIES) begin
      pace_sender();
      offer_reply(random_reply());
    end
    in_valid <= 1'b0;

    while (awaited_estimates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_estimates.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // receiver stall pattern: phases of random length, each with its own stall density
  initial begin
    int phase_len;
    int mode;
    @(posedge rst_n);
    forever begin
      phase_len = $urandom_range(4, 40);
      mode      = $urandom_range(0, 3);
      repeat (phase_len) begin
        @(posedge clk);
        if (!held && words_in >= HOLD_AT) begin
          // long hold-off so the block backs up into its input
          held = 1'b1;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= $urandom_range(0, 1);
          default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    estimate_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_estimates.size() == 0) begin
        report_mismatch("estimate word with nothing pending");
      end else begin
        want = awaited_estimates.pop_front();
        if (offset_est !== want.offset)
          report_mismatch($sformatf("offset_estimate got %0d want %0d",
                                    offset_est, want.offset));
        if (delay_est !== want.delay)
          report_mismatch($sformatf("one_way_delay got %0d want %0d",
                                    delay_est, want.delay));
        if (full_flag !== want.full)
          report_mismatch($sformatf("window_full got %b want %b", full_flag, want.full));
        if (clamp_flag !== want.clamped)
          report_mismatch($sformatf("rtt_clamped got %b want %b", clamp_flag, want.clamped));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
